[sv/ptw_pkg.sv]
package ptw_pkg;

   localparam int POOL_PAGES = 64;
   localparam int ENTRIES_PER_PAGE = 512;
   localparam int IDX_W = 9;
   localparam int PAGE_W = $clog2(POOL_PAGES);
   localparam int NFP_W = $clog2(POOL_PAGES + 1);
   localparam int ADDR_W = PAGE_W + IDX_W;
   localparam int TOTAL_ENTRIES = POOL_PAGES * ENTRIES_PER_PAGE;
   localparam int PPN_W = 40;
   localparam int ENTRY_W = 64;
   // one tag bit above the entry: written while its page was allocated
   localparam int RAM_W = ENTRY_W + 1;

   localparam logic [1:0] LVL_LEAF = 2'd3;

   typedef enum logic {
      OP_MAP   = 1'b0,
      OP_UNMAP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_NOMEM   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             subtract;
      logic [PPN_W-1:0] a;
      logic [PPN_W-1:0] b;
   } alu_op_type;

   typedef struct packed {
      logic [PPN_W-1:0] page_num;
      logic             in_pool;
   } alu_result_type;

endpackage

[sv/ptw_ram.sv]
module ptw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/ptw_alu.sv]
module ptw_alu
   import ptw_pkg::*;
(
   input  alu_op_type     op_in,
   output alu_result_type result
);

   logic [PPN_W-1:0] b_eff;
   logic [PPN_W-1:0] sum;

   // one 40-bit adder: link page minus base, or base plus new page
   assign b_eff = op_in.b ^ {PPN_W{op_in.subtract}};
   assign sum = op_in.a + b_eff + PPN_W'(op_in.subtract);

   assign result.page_num = sum;
   assign result.in_pool = (sum < PPN_W'(POOL_PAGES));

endmodule

[sv/page_table_map_unmap_walker.sv]
// Channel | Ports                                   | Direction
// req     | req_valid/req_ready + request fields    | in
// rsp     | rsp_valid/rsp_ready + status, entry     | out
// csr     | csr_write_enable, csr_write_data        | in, write only
//
// A request is accepted in idle, then each table level it reaches is read and then checked
// (and maybe written), and the walk ends in finish; the single RAM port sets this order.
// After reset the pool is swept to zero, one entry a cycle, over all POOL_PAGES*512
// entries (32768 at 64 pages); no request is taken meanwhile.
// The finished word waits in the rsp register; a new request is taken while it waits,
// but the next one stalls at finish until the old word is taken.
module page_table_map_unmap_walker
   import ptw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [47:0]       req_virtual_address,
   input  logic [51:0]       req_physical_address,
   input  logic              req_allow_write,
   input  logic              req_allow_execute,
   input  logic              req_allow_user,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [ENTRY_W-1:0] rsp_entry_value,
   input  logic              csr_write_enable,
   input  logic [PPN_W-1:0]  csr_write_data
);

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [NFP_W-1:0] nfp_ff, nfp_in;
   logic [PPN_W-1:0] base_ff;
   logic [1:0] lvl_ff, lvl_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   op_type op_ff, op_in;
   logic [35:0] va_ff, va_in;
   logic [39:0] pa_ff, pa_in;
   logic wr_ff, wr_in, ex_ff, ex_in, us_ff, us_in;
   status_type status_ff, status_in;
   logic [ENTRY_W-1:0] value_ff, value_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0] rsp_value_ff, rsp_value_in;

   logic ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [RAM_W-1:0] ram_wdata, ram_rdata;
   logic [IDX_W-1:0] idx;
   logic [ENTRY_W-1:0] entry, wr_entry;
   logic page_alloc, present, is_leaf, have_room, alloc, is_map, finish_load;
   alu_op_type alu_op;
   alu_result_type alu_res;

   ptw_ram #(.WIDTH(RAM_W), .DEPTH(TOTAL_ENTRIES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   ptw_alu u_alu (
      .op_in  (alu_op),
      .result (alu_res)
   );

   always_comb begin
      case (lvl_ff)
         2'd0: idx = va_ff[35:27];
         2'd1: idx = va_ff[26:18];
         2'd2: idx = va_ff[17:9];
         default: idx = va_ff[8:0];
      endcase
   end

   // an entry of an allocated page that predates the allocation reads as zero
   assign page_alloc = (NFP_W'(page_ff) < nfp_ff);
   assign entry = (page_alloc && !ram_rdata[ENTRY_W]) ? '0 : ram_rdata[ENTRY_W-1:0];
   assign present = entry[0];
   assign is_leaf = (lvl_ff == LVL_LEAF);
   assign is_map = (op_ff == OP_MAP);
   assign have_room = (nfp_ff < NFP_W'(POOL_PAGES));
   assign alloc = !is_leaf && !present && is_map && have_room;

   assign alu_op.subtract = present;
   assign alu_op.a = present ? entry[51:12] : base_ff;
   assign alu_op.b = present ? base_ff : PPN_W'(nfp_ff);

   assign finish_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_W'(TOTAL_ENTRIES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: state_in = ST_CHECK;
         ST_CHECK: begin
            if (is_leaf) state_in = ST_FINISH;
            else if (present ? alu_res.in_pool : alloc) state_in = ST_READ;
            else state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      clr_in = clr_ff;
      nfp_in = nfp_ff;
      lvl_in = lvl_ff;
      page_in = page_ff;
      op_in = op_ff;
      va_in = va_ff;
      pa_in = pa_ff;
      wr_in = wr_ff;
      ex_in = ex_ff;
      us_in = us_ff;
      status_in = status_ff;
      value_in = value_ff;
      ram_we = 1'b0;
      wr_entry = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = op_type'(req_op);
               va_in = req_virtual_address[47:12];
               pa_in = req_physical_address[51:12];
               wr_in = req_allow_write;
               ex_in = req_allow_execute;
               us_in = req_allow_user;
               lvl_in = 2'd0;
               page_in = '0;
               value_in = '0;
            end
         end
         ST_CHECK: begin
            if (is_leaf) begin
               if (is_map) begin
                  if (present) begin
                     status_in = STATUS_INVALID;
                  end else begin
                     wr_entry = {~ex_ff, 11'd0, pa_ff, 9'd0, us_ff, wr_ff, 1'b1};
                     ram_we = 1'b1;
                     value_in = wr_entry;
                     status_in = STATUS_DONE;
                  end
               end else begin
                  if (present) begin
                     ram_we = 1'b1;
                     status_in = STATUS_DONE;
                  end else begin
                     status_in = STATUS_INVALID;
                  end
               end
            end else if (present) begin
               if (alu_res.in_pool) begin
                  page_in = alu_res.page_num[PAGE_W-1:0];
                  lvl_in = lvl_ff + 1'b1;
               end else begin
                  status_in = is_map ? STATUS_NOMEM : STATUS_INVALID;
               end
            end else if (alloc) begin
               // link a fresh page: present, writable, user
               wr_entry = {12'd0, alu_res.page_num, 12'h007};
               ram_we = 1'b1;
               nfp_in = nfp_ff + 1'b1;
               page_in = nfp_ff[PAGE_W-1:0];
               lvl_in = lvl_ff + 1'b1;
            end else begin
               status_in = is_map ? STATUS_NOMEM : STATUS_INVALID;
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_addr = (state_ff == ST_CLEAR) ? clr_ff : {page_ff, idx};
   // tag against the allocation count after this cycle, so a self link survives
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0
                      : {(NFP_W'(page_ff) < nfp_in), wr_entry};

   assign rsp_valid_in = finish_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_status_in = finish_load ? status_ff : rsp_status_ff;
   assign rsp_value_in = finish_load ? value_ff : rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         nfp_ff <= NFP_W'(1);
         base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         nfp_ff <= nfp_in;
         if (csr_write_enable) base_ff <= csr_write_data;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      page_ff <= page_in;
      op_ff <= op_in;
      va_ff <= va_in;
      pa_ff <= pa_in;
      wr_ff <= wr_in;
      ex_ff <= ex_in;
      us_ff <= us_in;
      status_ff <= status_in;
      value_ff <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;

   a_nfp_range: assert property (@(posedge clock) disable iff (reset)
      (nfp_ff != '0) && (nfp_ff <= NFP_W'(POOL_PAGES)))
      else $error("allocation count out of range");

   a_alloc_only_on_map: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (nfp_ff != $past(nfp_ff)) |->
      ($past(state_ff) == ST_CHECK) && ($past(op_ff) == OP_MAP)
      && ($past(lvl_ff) != LVL_LEAF) && (nfp_ff == $past(nfp_ff) + 1'b1))
      else $error("page allocated outside a map walk");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response word loaded outside finish");

endmodule

[bench/tb_top.sv]
module tb_top;
   import ptw_pkg::*;

   localparam logic [63:0] ENTRY_ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
   localparam logic [63:0] ENTRY_NOEXEC    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ENTRY_PRESENT   = 64'h0000_0000_0000_0001;
   localparam logic [63:0] ENTRY_WRITE     = 64'h0000_0000_0000_0002;
   localparam logic [63:0] ENTRY_USER      = 64'h0000_0000_0000_0004;
   localparam logic [63:0] TABLE_LINK_BITS = ENTRY_PRESENT | ENTRY_WRITE | ENTRY_USER;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_REPORTS    = 10;
   localparam int KNOWN_DEPTH    = 128;

   typedef struct {
      op_type      op;
      logic [47:0] va;
      logic [51:0] pa;
      logic        wr;
      logic        ex;
      logic        us;
   } walk_request_type;

   typedef struct {
      status_type   status;
      logic [63:0]  entry;
   } walk_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = 1'b0;
   logic [47:0]        req_virtual_address = '0;
   logic [51:0]        req_physical_address = '0;
   logic               req_allow_write = 1'b0;
   logic               req_allow_execute = 1'b0;
   logic               req_allow_user = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [ENTRY_W-1:0] rsp_entry_value;
   logic               csr_write_enable = 1'b0;
   logic [PPN_W-1:0]   csr_write_data = '0;

   page_table_map_unmap_walker uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_virtual_address  (req_virtual_address),
      .req_physical_address (req_physical_address),
      .req_allow_write      (req_allow_write),
      .req_allow_execute    (req_allow_execute),
      .req_allow_user       (req_allow_user),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_entry_value      (rsp_entry_value),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   class page_walk_scoreboard_type;
      logic [63:0]      pool_entry [TOTAL_ENTRIES];
      int               next_page;
      logic [PPN_W-1:0] base_page;
      walk_result_type  expected_words [$];
      int               mismatches;

      function new();
         foreach (pool_entry[i]) pool_entry[i] = '0;
         next_page = 1;
         base_page = '0;
         mismatches = 0;
      endfunction

      function void set_base(logic [PPN_W-1:0] value);
         base_page = value;
      endfunction

      // Follow the link at one slot, or allocate a fresh table behind it when growing.
      function bit descend(int pg, logic [8:0] idx, bit grow, output int child);
         int               slot;
         int               np;
         int               i;
         logic [63:0]      e;
         logic [PPN_W-1:0] rel;
         child = 0;
         slot = pg * ENTRIES_PER_PAGE + idx;
         e = pool_entry[slot];
         if (e[0]) begin
            rel = e[51:12] - base_page;
            if (rel >= POOL_PAGES) return 0;
            child = int'(rel);
            return 1;
         end
         if (!grow || next_page >= POOL_PAGES) return 0;
         np = next_page;
         next_page++;
         for (i = 0; i < ENTRIES_PER_PAGE; i++) pool_entry[np * ENTRIES_PER_PAGE + i] = '0;
         rel = base_page + PPN_W'(np);
         pool_entry[slot] = (({24'b0, rel} << 12) & ENTRY_ADDR_MASK) | TABLE_LINK_BITS;
         child = np;
         return 1;
      endfunction

      function bit find_leaf(logic [47:0] va, bit grow, output int slot);
         int pg;
         int lvl;
         pg = 0;
         slot = 0;
         for (lvl = 0; lvl < 3; lvl++)
            if (!descend(pg, va[(39 - 9 * lvl) +: 9], grow, pg)) return 0;
         slot = pg * ENTRIES_PER_PAGE + va[20:12];
         return 1;
      endfunction

      function void note_request(walk_request_type r);
         walk_result_type w;
         int              leaf;
         w.status = STATUS_DONE;
         w.entry = '0;
         if (r.op == OP_MAP) begin
            if (!find_leaf(r.va, 1'b1, leaf)) begin
               w.status = STATUS_NOMEM;
            end else if (pool_entry[leaf][0]) begin
               w.status = STATUS_INVALID;
            end else begin
               w.entry = ({12'b0, r.pa} & ENTRY_ADDR_MASK) | ENTRY_PRESENT;
               if (r.wr) w.entry |= ENTRY_WRITE;
               if (r.us) w.entry |= ENTRY_USER;
               if (!r.ex) w.entry |= ENTRY_NOEXEC;
               pool_entry[leaf] = w.entry;
            end
         end else begin
            if (find_leaf(r.va, 1'b0, leaf) && pool_entry[leaf][0])
               pool_entry[leaf] = '0;
            else
               w.status = STATUS_INVALID;
         end
         expected_words.push_back(w);
      endfunction

      function void check_response(logic [1:0] st, logic [63:0] ev);
         walk_result_type w;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response word: status %0d entry %h", st, ev);
            return;
         end
         w = expected_words.pop_front();
         if (st !== w.status || ev !== w.entry) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response mismatch: status exp %0d got %0d, entry exp %h got %h",
                        w.status, st, w.entry, ev);
         end
      endfunction
   endclass

   page_walk_scoreboard_type sb;
   logic [47:0]              known_va [$];
   bit                       quiet = 1'b0;
   int                       rsp_hold = 0;
   int                       idle_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver side: drop rsp_ready at random in bursts, unless quiet.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_hold = $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      walk_request_type seen;
      if (req_valid && req_ready) begin
         seen.op = op_type'(req_op);
         seen.va = req_virtual_address;
         seen.pa = req_physical_address;
         seen.wr = req_allow_write;
         seen.ex = req_allow_execute;
         seen.us = req_allow_user;
         sb.note_request(seen);
      end
      if (rsp_valid && rsp_ready) sb.check_response(rsp_status, rsp_entry_value);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic walk_request_type make_request(op_type op, logic [47:0] va,
                                                     logic [51:0] pa, logic [2:0] flags);
      walk_request_type r;
      r.op = op;
      r.va = va;
      r.pa = pa;
      {r.wr, r.ex, r.us} = flags;
      return r;
   endfunction

   // Mostly revisit addresses under tables already built, so the pool lasts.
   function automatic walk_request_type random_request();
      walk_request_type r;
      logic [47:0]      ka;
      int               pick;
      pick = $urandom_range(0, 99);
      r.pa = 52'({$urandom(), $urandom()});
      r.wr = 1'($urandom_range(0, 1));
      r.ex = 1'($urandom_range(0, 1));
      r.us = 1'($urandom_range(0, 1));
      r.op = ($urandom_range(0, 99) < 70) ? OP_MAP : OP_UNMAP;
      if (known_va.size() == 0 || pick < 2) begin
         r.va = 48'({$urandom(), $urandom()});
      end else begin
         ka = known_va[$urandom_range(0, known_va.size() - 1)];
         if (pick < 6) begin
            r.va = {ka[47:30], 18'($urandom()), 12'($urandom())};
         end else if (pick < 55) begin
            r.va = {ka[47:21], 9'($urandom()), 12'($urandom())};
         end else begin
            r.va = {ka[47:12], 12'($urandom())};
            r.op = $urandom_range(0, 1) ? OP_UNMAP : OP_MAP;
         end
      end
      return r;
   endfunction

   task automatic send_request(walk_request_type r);
      if (r.op == OP_MAP) begin
         known_va.push_back(r.va);
         if (known_va.size() > KNOWN_DEPTH) void'(known_va.pop_front());
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_op               <= r.op;
      req_virtual_address  <= r.va;
      req_physical_address <= r.pa;
      req_allow_write      <= r.wr;
      req_allow_execute    <= r.ex;
      req_allow_user       <= r.us;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_base(logic [PPN_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      sb.set_base(value);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(int count);
      repeat (count) send_request(random_request());
      finish_phase();
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // hold until the pool sweep after reset is over
      do @(posedge clock); while (req_ready !== 1'b1);
      write_base('0);

      send_request(make_request(OP_MAP, 48'h0, 52'h0, 3'b000));
      send_request(make_request(OP_MAP, 48'h0000_0000_0FFF, 52'h1_2345_6789_A000, 3'b111));
      send_request(make_request(OP_UNMAP, 48'h0, 52'h0, 3'b000));
      send_request(make_request(OP_UNMAP, 48'h0, '1, 3'b111));
      send_request(make_request(OP_UNMAP, 48'h1234_5678_9000, 52'h0, 3'b000));
      send_request(make_request(OP_MAP, '1, '1, 3'b111));
      send_request(make_request(OP_MAP, '1, 52'hA_BCDE_F012_3456, 3'b000));
      send_request(make_request(OP_MAP, 48'hFFFF_FFE0_0000, 52'h5_5555_5555_5555, 3'b101));
      send_request(make_request(OP_MAP, 48'h0000_0000_1000, 52'h8_0000_0000_0000, 3'b010));
      send_request(make_request(OP_MAP, 48'h0080_0000_0000, 52'hF_FFFF_FFFF_F000, 3'b001));
      send_request(make_request(OP_UNMAP, '1, 52'h0, 3'b000));
      send_request(make_request(OP_UNMAP, 48'hFFFF_FFFF_F000, 52'h0, 3'b000));
      send_request(make_request(OP_MAP, '1, 52'h0_0000_0000_1FFF, 3'b110));
      send_request(make_request(OP_MAP, 48'h0000_4020_1000, 52'h3_3333_3333_3333, 3'b011));
      send_request(make_request(OP_UNMAP, 48'h0000_4020_2000, 52'h0, 3'b000));
      send_request(make_request(OP_MAP, 48'h0000_0000_2000, 52'h0_0000_0000_0FFF, 3'b011));
      send_request(make_request(OP_MAP, 48'h0000_0000_3ABC, 52'hC_0000_0000_0000, 3'b100));
      finish_phase();

      run_phase(400);
      // shift the pool base so existing links land on other pages or outside
      write_base('1);
      run_phase(150);
      write_base('0);
      run_phase(300);
      write_base(PPN_W'({$urandom(), $urandom()}));
      run_phase(100);
      write_base(PPN_W'(1));
      run_phase(150);
      write_base('0);
      quiet = 1'b1;
      run_phase(380);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[sim.f]
sv/ptw_pkg.sv
sv/ptw_ram.sv
sv/ptw_alu.sv
sv/page_table_map_unmap_walker.sv
bench/tb_top.sv
